[hdl/ptd_pkg.sv]
// ptd_pkg: shared types and constants of the periodic task dispatcher
// sizes of the slot table, stream payload widths, codes and the result record
// depends on nothing; imported by periodic_task_dispatcher_core
package ptd_pkg;

    // slot table
    localparam int MAX_SLOTS   = 8;
    localparam int RESULTS_MAX = 8;
    localparam int SLOT_IDX_W  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int SLOT_CNT_W  = $clog2(MAX_SLOTS + 1);
    localparam int DISP_CNT_W  = $clog2(RESULTS_MAX + 1);

    // field widths
    localparam int TIME_W     = 32;
    localparam int TASK_IDX_W = 3;
    localparam int STATUS_W   = 2;

    // stream payloads, packed from bit 0 and padded to whole bytes
    localparam int IN_FIELDS_W  = TIME_W + TIME_W + 1;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = TASK_IDX_W + STATUS_W + 3 * TIME_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    // request kind on s_tuser
    localparam logic KIND_TICK = 1'b0;
    localparam logic KIND_ADD  = 1'b1;

    // result kind on m_tuser
    localparam logic RKIND_DISPATCH = 1'b0;
    localparam logic RKIND_ADD      = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ADD_OK      = 2'd0,
        ADD_FULL    = 2'd1,
        ADD_INVALID = 2'd2
    } add_status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ADD,
        S_SCAN,
        S_FLUSH
    } state_t;

    typedef struct packed {
        logic                  rkind;
        logic [TASK_IDX_W-1:0] task_idx;
        add_status_t           status;
        logic [TIME_W-1:0]     lateness;
        logic [TIME_W-1:0]     runs;
        logic [TIME_W-1:0]     worst;
        logic                  last;
    } result_t;

endpackage

[hdl/periodic_task_dispatcher_core.sv]
// periodic_task_dispatcher_core: slot table of periodic tasks with add and tick requests
// holds the slot storage, the scan sequencer and the shared slot datapath
// depends on ptd_pkg
//
// A request on the s_ stream is either an add (s_tuser high) or a tick (s_tuser low).
// An add takes the next free slot, due at now plus period, and answers with a single
// status result; a full table is reported before a zero period or a missing handler.
// A tick walks the slots in index order, one slot per clock unless the output stalls,
// through one shared subtract, compare and add datapath, and gives one dispatch result
// for every enabled slot whose due time has been reached (now minus due, read as signed,
// not negative); that slot's run count, worst lateness and due time are updated as it is
// dispatched. m_tlast marks the final result of a request; a tick with nothing due gives
// no result. The block takes one request at a time: an add is accepted, then answers;
// a tick is accepted, steps through each slot, ends the scan and hands over the final
// result; both wait while m_tready holds the output register. The next request is taken
// as soon as the last result sits in the output register, before it has been taken
// downstream.
// There are no configuration registers; reset disables every slot.
module periodic_task_dispatcher_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    // request stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // now[31:0], period[63:32], handler_present[64], zero pad
    input  logic [ptd_pkg::IN_TDATA_W-1:0] s_tdata,
    // kind
    input  logic                           s_tuser,
    // result stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // task_index[2:0], add_status[4:3], lateness_ms[36:5], run_count[68:37],
    // worst_lateness_ms[100:69], zero pad
    output logic [ptd_pkg::OUT_TDATA_W-1:0] m_tdata,
    // result_kind
    output logic                           m_tuser,
    // last
    output logic                           m_tlast
);
    import ptd_pkg::*;

    // sequencer
    state_t state_reg, state_next;

    // captured request
    logic [TIME_W-1:0] now_reg;
    logic [TIME_W-1:0] period_reg;
    logic              handler_reg;

    // slot table
    logic [TIME_W-1:0]    period_mem [MAX_SLOTS];
    logic [TIME_W-1:0]    due_mem    [MAX_SLOTS];
    logic [TIME_W-1:0]    run_mem    [MAX_SLOTS];
    logic [TIME_W-1:0]    worst_mem  [MAX_SLOTS];
    logic [MAX_SLOTS-1:0] enabled_reg;
    logic [SLOT_CNT_W-1:0] slots_used_reg;

    // scan position and dispatch count of the current tick
    logic [SLOT_CNT_W-1:0] idx_reg, idx_next;
    logic [DISP_CNT_W-1:0] cnt_reg, cnt_next;

    // held dispatch waiting to learn whether it is the final one, and the output register
    result_t pend_reg, pend_next;
    logic    pend_valid_reg, pend_valid_next;
    result_t out_reg, out_next;
    logic    m_valid_reg, m_valid_next;

    logic s_accept;
    logic out_free;
    logic scan_end;

    // shared slot datapath
    logic [SLOT_IDX_W-1:0] sel;
    logic [SLOT_IDX_W-1:0] add_slot;
    logic [TIME_W-1:0]     sum_a, sum_b, sum;
    logic [TIME_W-1:0]     late;
    logic                  slot_due;
    logic [TIME_W-1:0]     runs_new;
    logic [TIME_W-1:0]     worst_new;
    logic [31:0]           sel_wide;
    logic [31:0]           add_wide;

    // control of the current cycle
    logic hit;
    logic advance;
    logic add_write;

    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign scan_end = (idx_reg == SLOT_CNT_W'(MAX_SLOTS))
                   || (cnt_reg == DISP_CNT_W'(RESULTS_MAX));

    assign sel      = idx_reg[SLOT_IDX_W-1:0];
    assign add_slot = slots_used_reg[SLOT_IDX_W-1:0];
    assign sel_wide = 32'(idx_reg);
    assign add_wide = 32'(slots_used_reg);

    // one adder: now plus period on an add, due plus period on a dispatch
    assign sum_a = (state_reg == S_ADD) ? now_reg : due_mem[sel];
    assign sum_b = (state_reg == S_ADD) ? period_reg : period_mem[sel];
    assign sum   = sum_a + sum_b;

    // wrap-safe due test: difference read as signed is not negative
    assign late      = now_reg - due_mem[sel];
    assign slot_due  = enabled_reg[sel] && !late[TIME_W-1];
    assign runs_new  = run_mem[sel] + TIME_W'(1);
    assign worst_new = (late > worst_mem[sel]) ? late : worst_mem[sel];

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    state_next = (s_tuser == KIND_ADD) ? S_ADD : S_SCAN;
                end
            end
            S_ADD: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            S_SCAN: begin
                if (scan_end) begin
                    state_next = S_FLUSH;
                end
            end
            S_FLUSH: begin
                if (!pend_valid_reg || out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // datapath control and result formation
    always_comb begin
        hit             = 1'b0;
        advance         = 1'b0;
        add_write       = 1'b0;
        idx_next        = idx_reg;
        cnt_next        = cnt_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        out_next        = out_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    idx_next = '0;
                    cnt_next = '0;
                end
            end
            S_ADD: begin
                if (out_free) begin
                    out_next.rkind    = RKIND_ADD;
                    out_next.task_idx = '0;
                    out_next.lateness = '0;
                    out_next.runs     = '0;
                    out_next.worst    = '0;
                    out_next.last     = 1'b1;
                    if (slots_used_reg >= SLOT_CNT_W'(MAX_SLOTS)) begin
                        out_next.status = ADD_FULL;
                    end else if (!handler_reg || (period_reg == '0)) begin
                        out_next.status = ADD_INVALID;
                    end else begin
                        out_next.status   = ADD_OK;
                        out_next.task_idx = add_wide[TASK_IDX_W-1:0];
                        add_write         = 1'b1;
                    end
                    m_valid_next = 1'b1;
                end
            end
            S_SCAN: begin
                if (!scan_end) begin
                    if (!slot_due) begin
                        advance = 1'b1;
                    end else if (!pend_valid_reg || out_free) begin
                        advance = 1'b1;
                        hit     = 1'b1;
                    end
                end
                if (advance) begin
                    idx_next = idx_reg + SLOT_CNT_W'(1);
                end
                if (hit) begin
                    cnt_next = cnt_reg + DISP_CNT_W'(1);
                    // an earlier dispatch now known not to be the final one
                    if (pend_valid_reg) begin
                        out_next      = pend_reg;
                        out_next.last = 1'b0;
                        m_valid_next  = 1'b1;
                    end
                    pend_next.rkind    = RKIND_DISPATCH;
                    pend_next.task_idx = sel_wide[TASK_IDX_W-1:0];
                    pend_next.status   = ADD_OK;
                    pend_next.lateness = late;
                    pend_next.runs     = runs_new;
                    pend_next.worst    = worst_new;
                    pend_next.last     = 1'b0;
                    pend_valid_next    = 1'b1;
                end
            end
            S_FLUSH: begin
                if (pend_valid_reg && out_free) begin
                    out_next        = pend_reg;
                    out_next.last   = 1'b1;
                    m_valid_next    = 1'b1;
                    pend_valid_next = 1'b0;
                end
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            m_valid_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
            enabled_reg    <= '0;
            slots_used_reg <= '0;
            idx_reg        <= '0;
            cnt_reg        <= '0;
        end else begin
            state_reg      <= state_next;
            m_valid_reg    <= m_valid_next;
            pend_valid_reg <= pend_valid_next;
            idx_reg        <= idx_next;
            cnt_reg        <= cnt_next;
            if (add_write) begin
                enabled_reg[add_slot] <= 1'b1;
                slots_used_reg        <= slots_used_reg + SLOT_CNT_W'(1);
            end
        end
    end

    // payload registers and slot storage
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            now_reg     <= s_tdata[TIME_W-1:0];
            period_reg  <= s_tdata[2*TIME_W-1:TIME_W];
            handler_reg <= s_tdata[2*TIME_W];
        end
        pend_reg <= pend_next;
        out_reg  <= out_next;
        // a new slot starts with clear counters
        if (add_write) begin
            period_mem[add_slot] <= period_reg;
            due_mem[add_slot]    <= sum;
            run_mem[add_slot]    <= '0;
            worst_mem[add_slot]  <= '0;
        end
        if (hit) begin
            due_mem[sel]   <= sum;
            run_mem[sel]   <= runs_new;
            worst_mem[sel] <= worst_new;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = out_reg.rkind;
    assign m_tlast  = out_reg.last;
    assign m_tdata  = {
        (OUT_TDATA_W - OUT_FIELDS_W)'(0),
        out_reg.worst,
        out_reg.runs,
        out_reg.lateness,
        out_reg.status,
        out_reg.task_idx
    };

endmodule
